@@ src/aescbc_pkg.sv @@
// ----------------------------------------------------------------------------
// aescbc_pkg
// shared types, constants and byte functions for the aes-128 cbc block
// ----------------------------------------------------------------------------
package aescbc_pkg;

    localparam int ROUND_KEY_COUNT_DEF = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int BLOCK_W    = 128;
    localparam int COUNT_W    = 5;
    localparam int ROUND_W    = 4;
    localparam logic [ROUND_W-1:0] MAX_MIDDLE = 4'd9;
    localparam logic [COUNT_W-1:0] FULL_COUNT = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HI = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROUNDS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd5;

    typedef enum logic [1:0] {
        t_ST_IDLE,
        t_ST_INIT,
        t_ST_ROUND,
        t_ST_DONE
    } t_core_state;

    // one queued word from the front end to the cipher core
    typedef struct packed {
        logic [BLOCK_W-1:0] data;
        logic               first;
        logic               last;
        logic               bad_len;
        logic               decrypt;
        logic [ROUND_W-1:0] rounds;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    localparam logic [7:0] FWD_BOX [256] = '{
 8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
 8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
 8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
 8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
 8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
 8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
 8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
 8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
 8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
 8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
 8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
 8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
 8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
 8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
 8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
 8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] INV_BOX [256] = '{
 8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
 8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
 8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
 8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
 8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
 8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
 8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
 8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
 8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
 8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
 8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
 8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
 8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
 8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
 8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
 8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // byte i sits at bits [127-8i -: 8]
    function automatic logic [7:0] byte_at(input logic [BLOCK_W-1:0] s, input int i);
        return s[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic logic [BLOCK_W-1:0] fwd_round(input logic [BLOCK_W-1:0] s,
                                                     input logic mix);
        logic [BLOCK_W-1:0] t;
        logic [BLOCK_W-1:0] m;
        logic [7:0] a0, a1, a2, a3;
        t = '0;
        m = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BLOCK_W-1-8*(4*c+r) -: 8] = FWD_BOX[byte_at(s, 4*((c+r)%4)+r)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = byte_at(t, 4*c);
            a1 = byte_at(t, 4*c+1);
            a2 = byte_at(t, 4*c+2);
            a3 = byte_at(t, 4*c+3);
            m[BLOCK_W-1-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            m[BLOCK_W-1-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            m[BLOCK_W-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            m[BLOCK_W-1-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return mix ? m : t;
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] p, x;
        p = '0;
        x = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) p = p ^ x;
            x = xt(x);
        end
        return p;
    endfunction

    function automatic logic [BLOCK_W-1:0] inv_mix(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] m;
        logic [7:0] a0, a1, a2, a3;
        m = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = byte_at(s, 4*c);
            a1 = byte_at(s, 4*c+1);
            a2 = byte_at(s, 4*c+2);
            a3 = byte_at(s, 4*c+3);
            m[BLOCK_W-1-8*(4*c)   -: 8] = gmul(a0,4'd14)^gmul(a1,4'd11)^gmul(a2,4'd13)^gmul(a3,4'd9);
            m[BLOCK_W-1-8*(4*c+1) -: 8] = gmul(a0,4'd9)^gmul(a1,4'd14)^gmul(a2,4'd11)^gmul(a3,4'd13);
            m[BLOCK_W-1-8*(4*c+2) -: 8] = gmul(a0,4'd13)^gmul(a1,4'd9)^gmul(a2,4'd14)^gmul(a3,4'd11);
            m[BLOCK_W-1-8*(4*c+3) -: 8] = gmul(a0,4'd11)^gmul(a1,4'd13)^gmul(a2,4'd9)^gmul(a3,4'd14);
        end
        return m;
    endfunction

    // inverse shift rows then inverse sub bytes
    function automatic logic [BLOCK_W-1:0] inv_shsub(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BLOCK_W-1-8*(4*c+r) -: 8] = INV_BOX[byte_at(s, 4*((c-r+4)%4)+r)];
            end
        end
        return t;
    endfunction

endpackage

@@ src/aescbc_if.sv @@
// ----------------------------------------------------------------------------
// aescbc_if
// valid / ready channel carrying a generic payload
// ----------------------------------------------------------------------------
interface aescbc_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/aescbc_front.sv @@
// ----------------------------------------------------------------------------
// aescbc_front
// classifies input words, pads short encrypt blocks and queues them for the core
// ----------------------------------------------------------------------------
module aescbc_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [aescbc_pkg::BLOCK_W-1:0]     i_block,
    input  logic [aescbc_pkg::COUNT_W-1:0]     i_count,
    input  logic                               i_first,
    input  logic                               i_last,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_decrypt,
    input  logic [aescbc_pkg::ROUND_W-1:0]     i_rounds,
    output aescbc_pkg::t_job                   o_job,
    output logic                               o_job_valid,
    input  logic                               i_job_take
);
    // two-entry queue
    aescbc_pkg::t_job r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    aescbc_pkg::t_job w_job;
    logic [aescbc_pkg::BLOCK_W-1:0] w_mask;
    logic push, pop;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_mask[aescbc_pkg::BLOCK_W-1-8*i -: 8] =
                (i_decrypt || (aescbc_pkg::COUNT_W'(i) < i_count)) ? 8'hFF : 8'h00;
        end
        w_job.data    = i_block & w_mask;
        w_job.first   = i_first;
        w_job.last    = i_last;
        w_job.bad_len = i_decrypt && (i_count != aescbc_pkg::FULL_COUNT);
        w_job.decrypt = i_decrypt;
        w_job.rounds  = (i_rounds > aescbc_pkg::MAX_MIDDLE) ? aescbc_pkg::MAX_MIDDLE : i_rounds;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign pop         = i_job_take && o_job_valid;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= w_job;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !pop) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> (r_cnt == 2'd2)) else $error("full queue lost word");
endmodule

@@ src/aescbc_keyexp.sv @@
// ----------------------------------------------------------------------------
// aescbc_keyexp
// expands the cipher key one round key per cycle into a round key memory
// ----------------------------------------------------------------------------
module aescbc_keyexp #(
    parameter int ROUND_KEY_COUNT = aescbc_pkg::ROUND_KEY_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [aescbc_pkg::BLOCK_W-1:0] i_key,
    input  logic [$clog2(ROUND_KEY_COUNT)-1:0] i_rd_idx,
    output logic [aescbc_pkg::BLOCK_W-1:0] o_rd_key,
    output logic                           o_busy
);
    localparam int IW = $clog2(ROUND_KEY_COUNT);
    localparam logic [IW-1:0] LAST = IW'(ROUND_KEY_COUNT - 1);

    logic [aescbc_pkg::BLOCK_W-1:0] r_mem [ROUND_KEY_COUNT];
    logic [aescbc_pkg::BLOCK_W-1:0] r_cur;
    logic [IW-1:0]                  r_idx;
    logic [7:0]                     r_rc;
    logic                           r_busy;
    logic [aescbc_pkg::BLOCK_W-1:0] n_key;
    logic [31:0] w0, w1, w2, w3, rot;

    always_comb begin
        rot = {aescbc_pkg::FWD_BOX[r_cur[23:16]] ^ r_rc, aescbc_pkg::FWD_BOX[r_cur[15:8]],
               aescbc_pkg::FWD_BOX[r_cur[7:0]], aescbc_pkg::FWD_BOX[r_cur[31:24]]};
        w0 = r_cur[127:96] ^ rot;
        w1 = r_cur[95:64] ^ w0;
        w2 = r_cur[63:32] ^ w1;
        w3 = r_cur[31:0] ^ w2;
        n_key = {w0, w1, w2, w3};
    end

    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mem[0] <= i_key;
            r_cur    <= i_key;
        end else if (r_busy) begin
            r_mem[r_idx] <= n_key;
            r_cur        <= n_key;
        end
        o_rd_key <= r_mem[i_rd_idx];
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_rc   <= 8'h01;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= IW'(1);
            r_rc   <= 8'h01;
        end else if (r_busy) begin
            r_rc  <= aescbc_pkg::xt(r_rc);
            r_idx <= r_idx + IW'(1);
            if (r_idx == LAST) r_busy <= 1'b0;
        end
    end
endmodule

@@ src/aescbc_core.sv @@
// ----------------------------------------------------------------------------
// aescbc_core
// iterative round engine with cbc chaining and an output register
// ----------------------------------------------------------------------------
module aescbc_core #(
    parameter int ROUND_KEY_COUNT = aescbc_pkg::ROUND_KEY_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  aescbc_pkg::t_job               i_job,
    input  logic                           i_job_valid,
    output logic                           o_job_take,
    input  logic                           i_keys_busy,
    input  logic [aescbc_pkg::BLOCK_W-1:0] i_iv,
    output logic [$clog2(ROUND_KEY_COUNT)-1:0] o_key_idx,
    input  logic [aescbc_pkg::BLOCK_W-1:0] i_key,
    output logic [aescbc_pkg::BLOCK_W-1:0] o_result,
    output logic                           o_error,
    output logic                           o_last,
    output logic                           o_valid,
    input  logic                           i_ready
);
    localparam int IW = $clog2(ROUND_KEY_COUNT);
    localparam logic [IW-1:0] LAST_KEY = IW'(ROUND_KEY_COUNT - 1);

    aescbc_pkg::t_core_state r_st, n_st;
    aescbc_pkg::t_job        r_job;
    logic [aescbc_pkg::BLOCK_W-1:0] r_s, r_chain, r_prev;
    logic [aescbc_pkg::ROUND_W-1:0] r_step;
    logic [IW-1:0]                  r_kidx, n_kidx;
    logic                           out_free;
    logic [aescbc_pkg::BLOCK_W-1:0] w_fwd, w_inv;
    logic                           fin;
    logic                           out_load;

    // key index is sent the cycle before its key is needed, so r_kidx names the key in i_key now
    assign out_free   = !o_valid || i_ready;
    assign out_load   = (r_st == aescbc_pkg::t_ST_DONE) && out_free;
    assign o_job_take = (r_st == aescbc_pkg::t_ST_IDLE) && i_job_valid && !i_keys_busy;
    assign fin        = (r_step == r_job.rounds);
    assign w_fwd      = aescbc_pkg::fwd_round(r_s, !fin) ^ i_key;
    assign w_inv      = fin ? (r_s ^ i_key)
                            : aescbc_pkg::inv_shsub(aescbc_pkg::inv_mix(r_s ^ i_key));
    assign o_key_idx  = n_kidx;

    always_comb begin
        n_st   = r_st;
        n_kidx = r_kidx;
        case (r_st)
            aescbc_pkg::t_ST_IDLE: begin
                if (o_job_take) begin
                    n_st   = aescbc_pkg::t_ST_INIT;
                    n_kidx = i_job.decrypt ? LAST_KEY : '0;
                end
            end
            aescbc_pkg::t_ST_INIT: begin
                n_st = r_job.bad_len ? aescbc_pkg::t_ST_DONE : aescbc_pkg::t_ST_ROUND;
                if (r_job.decrypt) begin
                    n_kidx = (r_job.rounds == '0) ? '0 : IW'(r_job.rounds);
                end else begin
                    n_kidx = (r_job.rounds == '0) ? LAST_KEY : IW'(1);
                end
            end
            aescbc_pkg::t_ST_ROUND: begin
                if (fin) begin
                    n_st = aescbc_pkg::t_ST_DONE;
                end else if (r_job.decrypt) begin
                    n_kidx = IW'(r_job.rounds - r_step - 4'd1);
                end else begin
                    n_kidx = (r_step + 4'd1 == r_job.rounds) ? LAST_KEY
                                                             : IW'(r_step + 4'd2);
                end
            end
            aescbc_pkg::t_ST_DONE: begin
                if (out_free) n_st = aescbc_pkg::t_ST_IDLE;
            end
            default: n_st = aescbc_pkg::t_ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= aescbc_pkg::t_ST_IDLE;
            r_chain <= '0;
            o_valid <= 1'b0;
            r_kidx  <= '0;
        end else begin
            r_st   <= n_st;
            r_kidx <= n_kidx;
            if (o_valid && i_ready && !out_load) o_valid <= 1'b0;
            case (r_st)
                aescbc_pkg::t_ST_IDLE: begin
                    if (o_job_take) r_job <= i_job;
                end
                aescbc_pkg::t_ST_INIT: begin
                    r_step <= '0;
                    r_prev <= r_job.first ? i_iv : r_chain;
                    if (r_job.decrypt) begin
                        r_s <= aescbc_pkg::inv_shsub(r_job.data ^ i_key);
                    end else begin
                        r_s <= r_job.data ^ (r_job.first ? i_iv : r_chain) ^ i_key;
                    end
                end
                aescbc_pkg::t_ST_ROUND: begin
                    // last decrypt step folds in the chaining value
                    r_s    <= r_job.decrypt ? (fin ? (w_inv ^ r_prev) : w_inv) : w_fwd;
                    r_step <= r_step + 4'd1;
                end
                aescbc_pkg::t_ST_DONE: begin
                    if (out_free) begin
                        o_valid  <= 1'b1;
                        o_result <= r_job.bad_len ? '0 : r_s;
                        o_error  <= r_job.bad_len;
                        o_last   <= r_job.last;
                        if (!r_job.bad_len) r_chain <= r_job.decrypt ? r_job.data : r_s;
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |-> !i_keys_busy) else $error("job taken during key expansion");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == aescbc_pkg::t_ST_ROUND) |-> (r_step <= r_job.rounds))
        else $error("round counter overran");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
endmodule

@@ src/aes128_cbc_block_cipher.sv @@
// ----------------------------------------------------------------------------
// aes128_cbc_block_cipher
// aes-128 cbc encrypt / decrypt, one 128-bit word in, one word out
// ----------------------------------------------------------------------------
// a front end takes each input word, zero pads short encrypt blocks, flags a
// decrypt word whose byte count is not 16, and queues it (two entries) for the
// round engine. the engine runs one aes round per cycle from a round key
// memory: idle takes a word from the queue, init does the first key add, the
// round state runs the middle rounds (9 by default) and the final round, and
// done loads the output register, waiting while that register is still held;
// a decrypt word with a bad length skips the round state. the cbc chain ties
// each block to the previous result, so one word is in rounds at a time. a key
// write starts an expansion, one round key a cycle, during which no word enters
// the engine; after reset the all-zero key is expanded the same way. the final
// encrypt round and the first decrypt key add use the last round key (10 by
// default). length errors give zero data and leave the chain alone; first_block
// reloads the chain from the iv.
// ----------------------------------------------------------------------------
module aes128_cbc_block_cipher #(
    parameter int ROUND_KEY_COUNT = aescbc_pkg::ROUND_KEY_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [aescbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [aescbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    aescbc_if.sink                            in_ch,
    aescbc_if.source                          out_ch
);
    // input word: block_high, block_low, byte_count, first_block, last_block
    // output word: result_high, result_low, length_error, last_out
    logic [63:0] r_key_hi, r_key_lo, r_iv_hi, r_iv_lo;
    logic [3:0]  r_rounds;
    logic        r_decrypt;
    logic        r_kick;

    aescbc_pkg::t_job job;
    logic job_valid, job_take, keys_busy;
    logic [$clog2(ROUND_KEY_COUNT)-1:0] key_idx;
    logic [aescbc_pkg::BLOCK_W-1:0]     key;
    logic [aescbc_pkg::BLOCK_W-1:0]     res;
    logic err, lst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi  <= '0;
            r_key_lo  <= '0;
            r_iv_hi   <= '0;
            r_iv_lo   <= '0;
            r_rounds  <= aescbc_pkg::MAX_MIDDLE;
            r_decrypt <= 1'b0;
            r_kick    <= 1'b1;
        end else begin
            r_kick <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    aescbc_pkg::REG_KEY_HI: begin
                        r_key_hi <= i_cfg_data;
                        r_kick   <= 1'b1;
                    end
                    aescbc_pkg::REG_KEY_LO: begin
                        r_key_lo <= i_cfg_data;
                        r_kick   <= 1'b1;
                    end
                    aescbc_pkg::REG_IV_HI:  r_iv_hi   <= i_cfg_data;
                    aescbc_pkg::REG_IV_LO:  r_iv_lo   <= i_cfg_data;
                    aescbc_pkg::REG_ROUNDS: r_rounds  <= i_cfg_data[3:0];
                    aescbc_pkg::REG_MODE:   r_decrypt <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    aescbc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_block    (in_ch.data[134:7]),
        .i_count    (in_ch.data[6:2]),
        .i_first    (in_ch.data[1]),
        .i_last     (in_ch.data[0]),
        .i_valid    (in_ch.valid),
        .o_ready    (in_ch.ready),
        .i_decrypt  (r_decrypt),
        .i_rounds   (r_rounds),
        .o_job      (job),
        .o_job_valid(job_valid),
        .i_job_take (job_take)
    );

    aescbc_keyexp #(.ROUND_KEY_COUNT(ROUND_KEY_COUNT)) u_keyexp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick),
        .i_key   ({r_key_hi, r_key_lo}),
        .i_rd_idx(key_idx),
        .o_rd_key(key),
        .o_busy  (keys_busy)
    );

    aescbc_core #(.ROUND_KEY_COUNT(ROUND_KEY_COUNT)) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job),
        .i_job_valid(job_valid),
        .o_job_take (job_take),
        .i_keys_busy(keys_busy || r_kick),
        .i_iv       ({r_iv_hi, r_iv_lo}),
        .o_key_idx  (key_idx),
        .i_key      (key),
        .o_result   (res),
        .o_error    (err),
        .o_last     (lst),
        .o_valid    (out_ch.valid),
        .i_ready    (out_ch.ready)
    );

    assign out_ch.data = {res, err, lst};
endmodule

@@ dv/aes128_cbc_block_cipher_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aes128_cbc_block_cipher_test
// self-checking bench for the aes-128 cbc block cipher: a predictor of its own
// works out each result word as input words are accepted, and a monitor checks
// every output word against the oldest prediction, under random idling on
// both channels and, in two runs, a long output stall
// ----------------------------------------------------------------------------
module aes128_cbc_block_cipher_test;

    localparam int IN_W  = 2 * 64 + aescbc_pkg::COUNT_W + 2;
    localparam int OUT_W = 2 * 64 + 2;
    localparam int RKC   = aescbc_pkg::ROUND_KEY_COUNT_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 30;   // key expansion and engine latency, with margin
    localparam logic ENCRYPT = 1'b0;
    localparam logic DECRYPT = 1'b1;

    typedef struct packed {
        logic [127:0] data;
        logic         len_err;
        logic         last;
    } t_cipher_word;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [aescbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [aescbc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    aescbc_if #(.W(IN_W))  in_if ();
    aescbc_if #(.W(OUT_W)) out_if ();

    aes128_cbc_block_cipher u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_if.sink),
        .out_ch     (out_if.source)
    );

    // predictor state
    logic [127:0] cipher_key;
    logic [127:0] init_vec;
    logic [3:0]   mid_rounds;
    logic         mode;
    logic [127:0] chain;
    logic [127:0] round_keys [RKC];

    t_cipher_word expected_words [$];

    int mismatches;
    int words_sent;
    int words_checked;
    int len_errors_seen;
    int idle_cycles;
    bit input_gaps_on;
    bit output_stalls_on;
    int hold_request;

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // aes arithmetic
    // ------------------------------------------------------------------
    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) acc ^= a;
            a = dbl(a);
        end
        return acc;
    endfunction

    // byte n of a block sits at bits [127-8n -: 8]
    function automatic logic [127:0] shift_and_sub(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        int src;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? ((c - r + 4) % 4) : ((c + r) % 4);
                t[127-8*(4*c+r) -: 8] = inv ? aescbc_pkg::INV_BOX[s[127-8*(4*src+r) -: 8]]
                                            : aescbc_pkg::FWD_BOX[s[127-8*(4*src+r) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
        logic [3:0] fwd_coef [4];
        logic [3:0] inv_coef [4];
        logic [127:0] t;
        logic [7:0] v;
        fwd_coef = '{4'd2, 4'd3, 4'd1, 4'd1};
        inv_coef = '{4'd14, 4'd11, 4'd13, 4'd9};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int j = 0; j < 4; j++) begin
                    v ^= gf_times(s[127-8*(4*c+j) -: 8],
                                  inv ? inv_coef[(j-r+4)%4] : fwd_coef[(j-r+4)%4]);
                end
                t[127-8*(4*c+r) -: 8] = v;
            end
        end
        return t;
    endfunction

    task automatic expand_round_keys();
        logic [31:0] w [4*RKC];
        logic [31:0] t;
        logic [7:0]  rcon;
        rcon = 8'h01;
        for (int i = 0; i < 4; i++) w[i] = cipher_key[127-32*i -: 32];
        for (int i = 4; i < 4*RKC; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {aescbc_pkg::FWD_BOX[t[23:16]] ^ rcon, aescbc_pkg::FWD_BOX[t[15:8]],
                     aescbc_pkg::FWD_BOX[t[7:0]], aescbc_pkg::FWD_BOX[t[31:24]]};
                rcon = dbl(rcon);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int n = 0; n < RKC; n++)
            round_keys[n] = {w[4*n], w[4*n+1], w[4*n+2], w[4*n+3]};
    endtask

    // works out the result word of one accepted input word and, unless its length is bad, moves the chain
    task automatic predict_cipher_word(input logic [127:0] blk, input logic [4:0] cnt,
                                       input logic first, input logic last);
        t_cipher_word w;
        logic [127:0] s;
        logic [127:0] link;
        int rounds;
        rounds = (mid_rounds > aescbc_pkg::MAX_MIDDLE) ? aescbc_pkg::MAX_MIDDLE : mid_rounds;
        w.last = last;
        w.len_err = 1'b0;
        link = first ? init_vec : chain;
        if (mode == DECRYPT && cnt != aescbc_pkg::FULL_COUNT) begin
            // bad length: zero data, chain untouched even on a first block
            w.data = '0;
            w.len_err = 1'b1;
        end else if (mode == ENCRYPT) begin
            s = blk;
            for (int n = 0; n < 16; n++)
                if (n >= cnt) s[127-8*n -: 8] = 8'h00;
            s = s ^ link ^ round_keys[0];
            for (int r = 1; r <= rounds; r++)
                s = mix_cols(shift_and_sub(s, 1'b0), 1'b0) ^ round_keys[r];
            s = shift_and_sub(s, 1'b0) ^ round_keys[RKC-1];
            chain = s;
            w.data = s;
        end else begin
            s = shift_and_sub(blk ^ round_keys[RKC-1], 1'b1);
            for (int r = rounds; r >= 1; r--)
                s = shift_and_sub(mix_cols(s ^ round_keys[r], 1'b1), 1'b1);
            s = s ^ round_keys[0] ^ link;
            chain = blk;
            w.data = s;
        end
        expected_words.push_back(w);
    endtask

    // ------------------------------------------------------------------
    // shared helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input logic [aescbc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            aescbc_pkg::REG_KEY_HI: begin
                cipher_key[127:64] = value;
                expand_round_keys();
            end
            aescbc_pkg::REG_KEY_LO: begin
                cipher_key[63:0] = value;
                expand_round_keys();
            end
            aescbc_pkg::REG_IV_HI:  init_vec[127:64] = value;
            aescbc_pkg::REG_IV_LO:  init_vec[63:0] = value;
            aescbc_pkg::REG_ROUNDS: mid_rounds = value[3:0];
            aescbc_pkg::REG_MODE:   mode = value[0];
            default: ;
        endcase
        // let a key expansion finish before any word follows
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // stop offering, wait until every predicted word has come back, then settle
    task automatic drain();
        in_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_setup(input logic [127:0] key, input logic [127:0] iv,
                              input logic [3:0] rounds, input logic md);
        drain();
        write_reg(aescbc_pkg::REG_KEY_HI, key[127:64]);
        write_reg(aescbc_pkg::REG_KEY_LO, key[63:0]);
        write_reg(aescbc_pkg::REG_IV_HI, iv[127:64]);
        write_reg(aescbc_pkg::REG_IV_LO, iv[63:0]);
        write_reg(aescbc_pkg::REG_ROUNDS, 64'(rounds));
        write_reg(aescbc_pkg::REG_MODE, 64'(md));
    endtask

    // offers one word and returns at the edge where it is taken
    task automatic send_word(input logic [127:0] blk, input logic [4:0] cnt,
                             input logic first, input logic last);
        int gap;
        gap = input_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= {blk, cnt, first, last};
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_cipher_word(blk, cnt, first, last);
        words_sent++;
    endtask

    function automatic logic [127:0] rand_block();
        return {$urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    // one message in the current mode, short last block when encrypting, rare bad length when decrypting
    task automatic send_message(input int len);
        logic [4:0] cnt;
        for (int b = 0; b < len; b++) begin
            cnt = aescbc_pkg::FULL_COUNT;
            if (mode == ENCRYPT && b == len - 1) cnt = 5'($urandom_range(1, 16));
            if (mode == DECRYPT && $urandom_range(0, 19) == 0)
                cnt = 5'($urandom_range(1, 15));
            send_word(rand_block(), cnt, b == 0, b == len - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // output side: ready with random stalls and, on request, a hold-off
    // ------------------------------------------------------------------
    int hold_left;
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left = 0;
            stall_left = 0;
        end else begin
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (output_stalls_on && $urandom_range(0, 5) == 0) stall_left = pick_gap();
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_cipher_word got;
        t_cipher_word want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            words_checked++;
            if (got.len_err) len_errors_seen++;
            if (expected_words.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = expected_words.pop_front();
                if (got.data !== want.data)
                    report_mismatch($sformatf("data %h, want %h", got.data, want.data));
                if (got.len_err !== want.len_err)
                    report_mismatch($sformatf("length_error %b, want %b",
                                              got.len_err, want.len_err));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last_out %b, want %b", got.last, want.last));
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL aes128_cbc_block_cipher");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // known key first
        load_setup({64'h2B7E151628AED2A6, 64'hABF7158809CF4F3C},
                   {64'h0001020304050607, 64'h08090A0B0C0D0E0F},
                   aescbc_pkg::MAX_MIDDLE, ENCRYPT);
        // chain before any first block is zero
        send_word('0, aescbc_pkg::FULL_COUNT, 1'b0, 1'b0);
        send_word('1, aescbc_pkg::FULL_COUNT, 1'b1, 1'b0);
        send_word('1, 5'd1, 1'b0, 1'b0);        // one-byte block, rest padded
        send_word(rand_block(), 5'd15, 1'b0, 1'b1);
        send_word({64'h6BC1BEE22E409F96, 64'hE93D7E117393172A}, aescbc_pkg::FULL_COUNT,
                  1'b1, 1'b1);
        // mode change inside a message keeps the chain
        load_setup(cipher_key, init_vec, aescbc_pkg::MAX_MIDDLE, DECRYPT);
        send_word(rand_block(), aescbc_pkg::FULL_COUNT, 1'b0, 1'b0);
        send_word(rand_block(), 5'd7, 1'b1, 1'b0); // bad length on a first block
        send_word('1, aescbc_pkg::FULL_COUNT, 1'b1, 1'b0);
        send_word(rand_block(), 5'd1, 1'b0, 1'b0);
        send_word('0, aescbc_pkg::FULL_COUNT, 1'b0, 1'b1);
        // no middle rounds, all-ones key and iv
        load_setup('1, '1, 4'd0, ENCRYPT);
        send_word('0, aescbc_pkg::FULL_COUNT, 1'b1, 1'b0);
        send_word(rand_block(), 5'd8, 1'b0, 1'b1);
        load_setup('1, '1, 4'd0, DECRYPT);
        send_word(rand_block(), aescbc_pkg::FULL_COUNT, 1'b1, 1'b0);
        send_word(rand_block(), aescbc_pkg::FULL_COUNT, 1'b0, 1'b1);
        load_setup('0, '0, 4'd5, ENCRYPT);
        send_word(rand_block(), aescbc_pkg::FULL_COUNT, 1'b1, 1'b1);
    endtask

    task automatic test_random();
        int target;
        logic [3:0] rounds;
        target = words_sent + 500;
        while (words_sent < target) begin
            // half the time the full round count, else zero or anything between
            case ($urandom_range(0, 3))
                0: rounds = 4'd0;
                1: rounds = 4'($urandom_range(1, 8));
                default: rounds = aescbc_pkg::MAX_MIDDLE;
            endcase
            load_setup(rand_block(), rand_block(), rounds, 1'($urandom_range(0, 1)));
            input_gaps_on    = $urandom_range(0, 3) != 0;
            output_stalls_on = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(3, 8)) begin
                if ($urandom_range(0, 9) == 0)
                    // stray word: random flags and count
                    send_word(rand_block(), 5'($urandom_range(1, 16)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                else
                    send_message($urandom_range(1, 8));
            end
        end
        input_gaps_on = 1'b1;
        output_stalls_on = 1'b1;
    endtask

    // long output hold-off while words keep coming, so the input side backs up
    task automatic test_output_hold();
        load_setup(rand_block(), rand_block(), aescbc_pkg::MAX_MIDDLE, ENCRYPT);
        input_gaps_on = 1'b0;
        hold_request = 400;
        send_message(12);
        load_setup(cipher_key, init_vec, aescbc_pkg::MAX_MIDDLE, DECRYPT);
        hold_request = 300;
        send_message(12);
        input_gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        len_errors_seen = 0;
        idle_cycles = 0;
        hold_request = 0;
        input_gaps_on = 1'b1;
        output_stalls_on = 1'b1;
        cipher_key = '0;
        init_vec = '0;
        mid_rounds = aescbc_pkg::MAX_MIDDLE;
        mode = ENCRYPT;
        chain = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random();
        test_output_hold();
        drain();

        $display("covered %0d words sent, %0d checked, %0d length errors,",
                 words_sent, words_checked, len_errors_seen);
        $display("both modes, round counts 0 to 9, message chaining and output hold-off");
        if (mismatches == 0) begin
            $display("PASS aes128_cbc_block_cipher");
        end else begin
            $display("FAIL aes128_cbc_block_cipher");
        end
        $finish;
    end

endmodule
